// File: hw/rtl/lkvc_pkg.sv
// lkvc_pkg: types and constants shared by the lru key/value cache modules
// holds the request/result item structs, controller states and the
// command/status bundles between controller and datapath; no dependencies
`default_nettype none

package lkvc_pkg;

  // request codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_SET = 1'b1;

  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [4:0]  CAP_RESET  = 5'd16;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] key;
    logic signed [31:0] write_value;
  } lkvc_in_t;

  typedef struct packed {
    logic              hit;
    logic signed [31:0] read_value;
  } lkvc_out_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } lkvc_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } lkvc_cmd_t;

  typedef struct packed {
    logic is_get;
  } lkvc_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/lkvc_ctrl.sv
// lkvc_ctrl: two-state sequencer for the lru cache
// depends on lkvc_pkg; issues capture/execute commands and the result strobe
`default_nettype none

module lkvc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output logic                   out_valid,
  output lkvc_pkg::lkvc_cmd_t    cmd,
  input  wire lkvc_pkg::lkvc_sts_t sts
);
  import lkvc_pkg::*;

  lkvc_state_t state_r, state_nxt;
  logic        strobe_r, strobe_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    busy       = 1'b0;
    strobe_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = start;
      end
      ST_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
        strobe_nxt  = sts.is_get;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign out_valid = strobe_r;

  // result strobe lands in the cycle after execute, back in idle
  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_IDLE) && $past(state_r == ST_EXEC))
    else $error("result strobe without a preceding execute cycle");

endmodule

`default_nettype wire

// File: hw/rtl/lkvc_datapath.sv
// lkvc_datapath: key cam, recency ranks, fill count and value memory
// depends on lkvc_pkg; driven by capture/execute commands from lkvc_ctrl
`default_nettype none

module lkvc_datapath #(
  parameter int ENTRIES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lkvc_pkg::lkvc_in_t  in_item,
  input  wire logic                cfg_we,
  input  wire logic [4:0]          cfg_wdata,
  input  wire lkvc_pkg::lkvc_cmd_t cmd,
  output lkvc_pkg::lkvc_sts_t      sts,
  output lkvc_pkg::lkvc_out_t      out_item
);
  import lkvc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W = IDX_W;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [CMP_W-1:0] ENT_C = CMP_W'(ENTRIES);
  localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1);

  lkvc_in_t          req_r;
  logic [4:0]        cap_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [31:0]       key_r [ENTRIES];
  logic [AGE_W-1:0]  age_r [ENTRIES];
  logic [AGE_W-1:0]  age_nxt [ENTRIES];
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [31:0]       mem [ENTRIES];
  logic [31:0]       rdata_r;
  logic              hit_r;

  logic [ENTRIES-1:0] match_oh, old_oh, free_oh, valid_after;
  logic               found, old_found, free_found;
  logic [IDX_W-1:0]   hit_idx, free_idx, wr_idx;
  logic [AGE_W-1:0]   hit_age;
  logic [CNT_W-1:0]   fill_m1;
  logic [CMP_W-1:0]   cap_ext, eff_cap;
  logic               do_evict, is_set, insert, wr_en;

  assign is_set  = (req_r.req_type == REQ_SET);
  assign fill_m1 = fill_r - CNT_W'(1);

  // clamp capacity into 1..ENTRIES
  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_ext == '0) eff_cap = ONE_C;
    else if (cap_ext > ENT_C) eff_cap = ENT_C;
    else eff_cap = cap_ext;
  end
  assign do_evict = (CMP_W'(fill_r) >= eff_cap);

  // parallel key compare, lowest matching entry wins
  always_comb begin
    match_oh = '0;
    found    = 1'b0;
    hit_idx  = '0;
    hit_age  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!found && valid_r[i] && (key_r[i] == req_r.key)) begin
        found       = 1'b1;
        match_oh[i] = 1'b1;
        hit_idx     = IDX_W'(i);
        hit_age     = age_r[i];
      end
    end
  end

  // ranks form a permutation, so the oldest entry holds rank fill-1
  always_comb begin
    old_oh    = '0;
    old_found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!old_found && valid_r[i] && (CNT_W'(age_r[i]) == fill_m1)) begin
        old_found = 1'b1;
        old_oh[i] = 1'b1;
      end
    end
  end

  assign valid_after = do_evict ? (valid_r & ~old_oh) : valid_r;

  always_comb begin
    free_oh    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!free_found && !valid_after[i]) begin
        free_found = 1'b1;
        free_oh[i] = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign insert = cmd.execute && is_set && !found;
  assign wr_en  = cmd.execute && is_set;
  assign wr_idx = found ? hit_idx : free_idx;

  always_comb begin
    valid_nxt = valid_r;
    fill_nxt  = fill_r;
    for (int i = 0; i < ENTRIES; i++) age_nxt[i] = age_r[i];
    if (cmd.execute) begin
      if (found) begin
        // hit: entries more recent than the touched one age by one
        for (int i = 0; i < ENTRIES; i++) begin
          if (match_oh[i]) age_nxt[i] = '0;
          else if (valid_r[i] && (age_r[i] < hit_age)) age_nxt[i] = age_r[i] + AGE_W'(1);
        end
      end else if (is_set) begin
        for (int i = 0; i < ENTRIES; i++) begin
          valid_nxt[i] = valid_after[i] | free_oh[i];
          if (free_oh[i]) age_nxt[i] = '0;
          else if (valid_after[i]) age_nxt[i] = age_r[i] + AGE_W'(1);
          else age_nxt[i] = '0;
        end
        fill_nxt = do_evict ? fill_r : fill_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      valid_r <= '0;
      fill_r  <= '0;
      hit_r   <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) age_r[i] <= '0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      valid_r <= valid_nxt;
      fill_r  <= fill_nxt;
      for (int i = 0; i < ENTRIES; i++) age_r[i] <= age_nxt[i];
      if (cmd.execute) hit_r <= found;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_item;
    for (int i = 0; i < ENTRIES; i++) begin
      if (insert && free_oh[i]) key_r[i] <= req_r.key;
    end
  end

  // value store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= req_r.write_value;
    if (cmd.execute) rdata_r <= mem[hit_idx];
  end

  assign sts.is_get          = (req_r.req_type == REQ_GET);
  assign out_item.hit        = hit_r;
  assign out_item.read_value = hit_r ? rdata_r : MISS_VALUE;

  a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'($countones(valid_r)) == fill_r)
    else $error("fill count disagrees with valid entries");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(fill_r) <= ENT_C)
    else $error("fill count above entry count");

  a_evict_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    insert && do_evict |=> $stable(fill_r))
    else $error("insert with eviction changed the fill count");

endmodule

`default_nettype wire

// File: hw/rtl/lru_key_value_cache_top.sv
// lru_key_value_cache_top: fully associative key/value cache, lru replacement
// depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath
//
//   channel   ports                         handshake
//   request   start, busy, in_item          taken when start & !busy
//   result    out_valid, out_item           one-cycle strobe, no backpressure
//   config    cfg_we, cfg_wdata             capacity written when cfg_we
//
// each item passes through capture, then an execute state in which the
// key cam compare, rank update and value write all happen; busy is high there.
// a get's result strobes the cycle after execute, from the registered read of
// the value memory, and the next item can be taken in that same cycle.
// reset clears all entries at once; capacity returns to 16.
`default_nettype none

module lru_key_value_cache_top #(
  parameter int ENTRIES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire lkvc_pkg::lkvc_in_t in_item,
  output logic                    out_valid,
  output lkvc_pkg::lkvc_out_t     out_item,
  input  wire logic               cfg_we,
  input  wire logic [4:0]         cfg_wdata
);
  import lkvc_pkg::*;

  lkvc_cmd_t cmd;
  lkvc_sts_t sts;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  lkvc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: dv/lru_key_value_cache_top_test.sv
// lru_key_value_cache_top_test: self-checking testbench for the lru key/value cache
// drives get/set items and capacity writes, predicts every get result in-bench
// depends on lkvc_pkg and lru_key_value_cache_top
`default_nettype none

module lru_key_value_cache_top_test;
  import lkvc_pkg::*;

  localparam int ENTRIES      = 16;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  lkvc_in_t   in_item   = '0;
  logic       out_valid;
  lkvc_out_t  out_item;
  logic       cfg_we    = 1'b0;
  logic [4:0] cfg_wdata = CAP_RESET;

  always #1 clk = ~clk;

  lru_key_value_cache_top #(.ENTRIES(ENTRIES)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predicted cache contents
  bit          slot_valid [ENTRIES];
  logic [31:0] slot_key   [ENTRIES];
  logic [31:0] slot_data  [ENTRIES];
  int unsigned slot_age   [ENTRIES];
  int unsigned live_count   = 0;
  logic [4:0]  capacity_reg = CAP_RESET;

  lkvc_out_t   pending_reads[$];
  lkvc_out_t   oldest_read;
  logic [31:0] key_pool[$];
  int          fail_count  = 0;
  int          quiet_cycles = 0;
  int          burst_left  = 0;
  bit          gaps_on     = 1'b1;

  function automatic int unsigned capacity_limit();
    if (capacity_reg == 5'd0) return 1;
    if (capacity_reg > ENTRIES) return ENTRIES;
    return capacity_reg;
  endfunction

  function automatic int find_slot(logic [31:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < ENTRIES; i++)
      if (!slot_valid[i]) return i;
    return -1;
  endfunction

  // entries more recent than idx age by one, idx becomes newest
  function automatic void promote(int idx);
    int unsigned a;
    a = slot_age[idx];
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && i != idx && slot_age[i] < a) slot_age[i]++;
    slot_age[idx] = 0;
  endfunction

  function automatic void drop_slot(int idx);
    int unsigned a;
    a = slot_age[idx];
    slot_valid[idx] = 1'b0;
    slot_age[idx] = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && slot_age[i] > a) slot_age[i]--;
    if (live_count > 0) live_count--;
  endfunction

  function automatic void lookup_and_update(input lkvc_in_t req, output bit gives,
                                            output lkvc_out_t rd);
    int idx;
    int victim;
    int free_idx;
    idx = find_slot(req.key);
    gives = 1'b0;
    rd = '0;
    if (req.req_type == REQ_GET) begin
      gives = 1'b1;
      if (idx >= 0) begin
        promote(idx);
        rd.hit = 1'b1;
        rd.read_value = slot_data[idx];
      end else begin
        rd.hit = 1'b0;
        rd.read_value = MISS_VALUE;
      end
      return;
    end
    if (idx >= 0) begin
      slot_data[idx] = req.write_value;
      promote(idx);
      return;
    end
    free_idx = first_free();
    if (live_count >= capacity_limit() || free_idx < 0) begin
      victim = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (slot_valid[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
      if (victim >= 0) drop_slot(victim);
    end
    free_idx = first_free();
    if (free_idx < 0) return;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i]) slot_age[i]++;
    slot_valid[free_idx] = 1'b1;
    slot_key[free_idx]   = req.key;
    slot_data[free_idx]  = req.write_value;
    slot_age[free_idx]   = 0;
    live_count++;
  endfunction

  // start stays high across back-to-back items, drops only for a gap
  task automatic send_item(input logic rq, input logic [31:0] k, input logic [31:0] v);
    int gap;
    bit gives;
    lkvc_out_t rd;
    lkvc_in_t req;
    req.req_type    = rq;
    req.key         = k;
    req.write_value = v;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    start   = 1'b1;
    in_item = req;
    @(posedge clk);
    while (busy) @(posedge clk);
    lookup_and_update(req, gives, rd);
    if (gives) pending_reads.push_back(rd);
  endtask

  // a set gives no result, so let the block settle after the last read
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_reads.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] v);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    capacity_reg = v;
  endtask

  task automatic test_empty_cache();
    send_item(REQ_GET, 32'h0000_0000, $urandom);
    send_item(REQ_GET, 32'hFFFF_FFFF, $urandom);
    send_item(REQ_GET, 32'h8000_0000, $urandom);
  endtask

  task automatic test_extreme_keys();
    send_item(REQ_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(REQ_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(REQ_SET, 32'h0000_0000, 32'h0000_0000);
    // all-ones value on a hit looks like a miss except for the hit bit
    send_item(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(REQ_GET, 32'h8000_0000, 32'h0);
    send_item(REQ_GET, 32'h7FFF_FFFF, 32'h0);
    send_item(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(REQ_GET, 32'hFFFF_FFFF, 32'h0);
    send_item(REQ_SET, 32'h7FFF_FFFF, 32'h1234_5678);
    send_item(REQ_GET, 32'h7FFF_FFFF, 32'h0);
    send_item(REQ_GET, 32'h0000_0001, 32'h0);
  endtask

  task automatic test_capacity_edges();
    // capacity zero acts as one entry
    write_capacity(5'd0);
    send_item(REQ_SET, 32'd5, 32'd50);
    send_item(REQ_SET, 32'd6, 32'd60);
    send_item(REQ_GET, 32'd5, 32'd0);
    send_item(REQ_GET, 32'd6, 32'd0);
    write_capacity(CAP_RESET);
    for (int k = 10; k < 14; k++) send_item(REQ_SET, k, $urandom);
    // capacity below the live count: inserts evict one and keep the count level
    write_capacity(5'd2);
    send_item(REQ_SET, 32'd14, $urandom);
    send_item(REQ_GET, 32'd6, 32'd0);
    send_item(REQ_GET, 32'd10, 32'd0);
  endtask

  task automatic test_random_traffic();
    logic [4:0] caps[$] = '{5'd16, 5'd3, 5'd1, 5'd31, 5'd0, 5'd8,
                            5'd16, 5'd2, 5'd15, 5'd0};
    int n;
    logic rq;
    logic [31:0] k;
    caps.push_back(5'($urandom_range(0, 31)));
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      gaps_on = (p % 4 != 2);
      key_pool.delete();
      n = $urandom_range(2, 24);
      repeat (n) key_pool.push_back($urandom);
      if ($urandom_range(0, 1)) key_pool.push_back(32'h8000_0000);
      if ($urandom_range(0, 1)) key_pool.push_back(32'hFFFF_FFFF);
      repeat (100) begin
        rq = ($urandom_range(0, 9) < 6) ? REQ_GET : REQ_SET;
        k  = ($urandom_range(0, 9) == 0) ? $urandom
                                          : key_pool[$urandom_range(0, key_pool.size() - 1)];
        send_item(rq, k, $urandom);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hit=%0b value=%h",
                 $time, out_item.hit, out_item.read_value);
        fail_count++;
      end else begin
        oldest_read = pending_reads.pop_front();
        if (out_item.hit !== oldest_read.hit) begin
          $display("%0t: hit mismatch, expected %0b actual %0b",
                   $time, oldest_read.hit, out_item.hit);
          fail_count++;
        end
        if (out_item.read_value !== oldest_read.read_value) begin
          $display("%0t: read_value mismatch, expected %h actual %h",
                   $time, oldest_read.read_value, out_item.read_value);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    foreach (slot_valid[i]) begin
      slot_valid[i] = 1'b0;
      slot_age[i]   = 0;
    end
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_empty_cache();
    test_extreme_keys();
    test_capacity_edges();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
